>>> src/stsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared constants and types of the sparse triangular solver.
// ----------------------------------------------------------------------------
package stsc_pkg;

    localparam int MAX_ROWS_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 16;

    // Magnitude of the row numerator, rhs minus the clamped sum, stays below 2^62.
    localparam int MAG_W = 62;
    localparam int DMAG_W = 32;
    // The quotient keeps one guard bit above the 32-bit result.
    localparam int QUO_W = 33;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

>>> src/stsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_div
// Restoring unsigned divider, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
module stsc_div import stsc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  mag,
    input  logic [DMAG_W-1:0] dmag,
    output div_res_t          res
);

    localparam int DVD_W = MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DMAG_W:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DMAG_W-1:0] dmag_reg;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DMAG_W:0]   trial;
    logic              take;

    always_comb begin
        trial     = {rem_reg[DMAG_W-1:0], dvd_reg[DVD_W-1]};
        take      = trial >= {1'b0, dmag_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = DVD_W'(mag) << FRAC_BITS;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = take ? trial - {1'b0, dmag_reg} : trial;
            quo_next = {quo_reg[QUO_W-2:0], take};
            // A bit pushed out of the guard position means the quotient is far too big.
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        if (start) begin
            dmag_reg <= dmag;
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

endmodule

>>> src/sparse_triangular_solve_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_triangular_solve_csr
// Forward substitution over sparse rows in solve order, signed fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Ports                                  Content
// s_        in   s_tvalid s_tready s_tdata s_tuser s_tlast  one nonzero or empty-row marker
// m_        out  m_tvalid m_tready m_tdata              one solved row
//
// A nonzero passes through three steps: accept and solution memory read,
// multiply, accumulate. A row end then passes through a setup step, the
// bit-serial divider and a write-back step; a zero diagonal skips the
// divider and writes back in the setup step. The result then holds in the
// output register until the transaction is taken.
// Reset clears the control state and the accumulator; the solution memory is
// not cleared. Only one item is in flight, so a write-back always lands before
// the next read and no forwarding is needed.
// ----------------------------------------------------------------------------
module sparse_triangular_solve_csr import stsc_pkg::*; #(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // row_index[9:0], col_index[19:10], coef[51:20], rhs[83:52], diag[115:84], zero pad
    input  logic [119:0] s_tdata,
    // has_entry[0]
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // solved_row[9:0], solution[41:10], status[43:42], zero pad
    output logic [47:0]  m_tdata
);

    localparam int ADDR_W = $clog2(MAX_ROWS);
    localparam int IDX_W  = (ADDR_W > 10) ? ADDR_W : 10;
    localparam logic [IDX_W:0] ROWS_L = (IDX_W + 1)'(MAX_ROWS);
    localparam logic signed [64:0] ACC_HI = 65'sd1 <<< 61;
    localparam logic signed [64:0] ACC_LO = -(65'sd1 <<< 61);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_FIN  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Solution memory, one read port and one write port.
    logic [31:0] sol_mem [MAX_ROWS];
    logic [31:0] rd_data_reg;

    logic [9:0]         row_reg;
    logic               col_ok_reg;
    logic signed [31:0] coef_reg, rhs_reg, diag_reg;
    logic               last_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic               acc_ovf_reg, acc_ovf_next;
    logic               neg_reg;
    logic [31:0]        sol_reg, sol_next;
    logic [1:0]         status_reg, status_next;

    logic               accept;
    logic [IDX_W-1:0]   col_ext, row_ext;
    logic signed [63:0] term;
    logic signed [64:0] sum;
    logic signed [63:0] num;
    logic [63:0]        mag_full;
    logic [DMAG_W-1:0]  dmag;
    logic               div_start;
    div_res_t           div_res;
    logic [QUO_W-1:0]   lim;
    logic               sat;
    logic               wr_en;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign col_ext  = IDX_W'(s_tdata[19:10]);
    assign row_ext  = IDX_W'(row_reg);

    // Floor shift of the product: arithmetic shift rounds toward minus infinity.
    assign term = prod_reg >>> FRAC_BITS;
    assign sum  = {acc_reg[63], acc_reg} + {term[63], term};

    assign num      = 64'(rhs_reg) - acc_reg;
    assign mag_full = num[63] ? 64'(-num) : 64'(num);
    assign dmag     = diag_reg[31] ? DMAG_W'(-diag_reg) : DMAG_W'(diag_reg);
    assign div_start = (state_reg == S_FIN) && (diag_reg != 32'sd0);

    stsc_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (mag_full[MAG_W-1:0]),
        .dmag    (dmag),
        .res     (div_res)
    );

    assign lim = neg_reg ? (QUO_W'(1) << 31) : ((QUO_W'(1) << 31) - 1'b1);
    assign sat = div_res.ovf || (div_res.quo > lim);

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        acc_ovf_next = acc_ovf_reg;
        sol_next     = sol_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        state_next = S_MUL;
                    end else if (s_tlast) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL: begin
                state_next = S_ACC;
            end
            S_ACC: begin
                if (sum > ACC_HI) begin
                    acc_next     = 64'(ACC_HI);
                    acc_ovf_next = 1'b1;
                end else if (sum < ACC_LO) begin
                    acc_next     = 64'(ACC_LO);
                    acc_ovf_next = 1'b1;
                end else begin
                    acc_next = 64'(sum);
                end
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (diag_reg == 32'sd0) begin
                    sol_next     = '0;
                    status_next  = STATUS_ZERO;
                    wr_en        = 1'b1;
                    acc_next     = '0;
                    acc_ovf_next = 1'b0;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    if (sat) begin
                        sol_next = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        sol_next = neg_reg ? 32'(-div_res.quo[31:0]) : div_res.quo[31:0];
                    end
                    status_next  = (sat || acc_ovf_reg) ? STATUS_SAT : STATUS_OK;
                    wr_en        = 1'b1;
                    acc_next     = '0;
                    acc_ovf_next = 1'b0;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            acc_ovf_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            acc_ovf_reg <= acc_ovf_next;
        end
        sol_reg    <= sol_next;
        status_reg <= status_next;
        if (accept) begin
            row_reg    <= s_tdata[9:0];
            col_ok_reg <= {1'b0, col_ext} < ROWS_L;
            coef_reg   <= s_tdata[51:20];
            rhs_reg    <= s_tdata[83:52];
            diag_reg   <= s_tdata[115:84];
            last_reg   <= s_tlast;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= coef_reg * (col_ok_reg ? $signed(rd_data_reg) : 32'sd0);
        end
        if (state_reg == S_FIN) begin
            // Zero numerator gives a non-negative quotient.
            neg_reg <= (num[63] != diag_reg[31]) && (num != 64'sd0);
        end
    end

    // Memory ports: read on acceptance, write the solved row at the row end.
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= sol_mem[col_ext[ADDR_W-1:0]];
        end
        if (wr_en && ({1'b0, row_ext} < ROWS_L)) begin
            sol_mem[row_ext[ADDR_W-1:0]] <= sol_next;
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'b0, status_reg, sol_reg, row_reg};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse triangular solver. Rows of nonzeros are
// streamed in solve order; a scoreboard predicts each solved row and compares
// its row, solution and status with the result stream under varied backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import stsc_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int CYC_LIMIT = 1500000;

    // Predicts solved rows from accepted transactions and checks results.
    class solve_scoreboard;
        logic [31:0] x_mem [MAX_ROWS_DEF];
        longint      acc;
        bit          acc_clamped;
        logic [43:0] pending [$];
        int          mismatches;
        int          rows_checked;

        function new();
            acc = 0;
            acc_clamped = 0;
            mismatches = 0;
            rows_checked = 0;
            foreach (x_mem[i]) x_mem[i] = '0;
        endfunction

        // Rounds the quotient toward zero and clamps it to 32 bits.
        function logic [31:0] divide(longint num, longint d, ref logic [1:0] st);
            bit neg;
            longint unsigned mag, dmag, lim, q1, r1, q;
            neg  = (num < 0) != (d < 0);
            mag  = (num < 0) ? -num : num;
            dmag = (d < 0) ? -d : d;
            if (mag == 0) neg = 0;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            q1  = mag / dmag;
            if (q1 > (lim >> FRAC)) begin
                st = STATUS_SAT;
                return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            r1 = mag % dmag;
            q  = (q1 << FRAC) + ((r1 << FRAC) / dmag);
            if (q > lim) begin
                st = STATUS_SAT;
                return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            return neg ? 32'(-q) : 32'(q);
        endfunction

        function void note_item(logic [119:0] d, bit has_entry, bit last);
            logic [9:0]  row, col;
            longint      coef, rhs, dg, term;
            logic [31:0] sol;
            logic [1:0]  st;
            row  = d[9:0];
            col  = d[19:10];
            coef = longint'(signed'(d[51:20]));
            rhs  = longint'(signed'(d[83:52]));
            dg   = longint'(signed'(d[115:84]));
            if (has_entry) begin
                term = (coef * longint'(signed'(x_mem[col]))) >>> FRAC;
                acc  = acc + term;
                if (acc > (longint'(1) <<< 61)) begin
                    acc = longint'(1) <<< 61;
                    acc_clamped = 1;
                end else if (acc < -(longint'(1) <<< 61)) begin
                    acc = -(longint'(1) <<< 61);
                    acc_clamped = 1;
                end
            end
            if (!last) return;
            st = STATUS_OK;
            if (dg == 0) begin
                sol = '0;
                st  = STATUS_ZERO;
            end else begin
                sol = divide(rhs - acc, dg, st);
                if (acc_clamped) st = STATUS_SAT;
            end
            x_mem[row]  = sol;
            acc         = 0;
            acc_clamped = 0;
            pending.insert(pending.size(), {st, sol, row});
        endfunction

        function void check_row(logic [47:0] d);
            logic [43:0] want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row=%0d sol=%h st=%0d",
                             d[9:0], d[41:10], d[43:42]);
                return;
            end
            want = pending.pop_front();
            rows_checked++;
            if (d[43:0] !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: row %0d/%0d sol %h/%h status %0d/%0d (exp/act)",
                             want[9:0], d[9:0], want[41:10], d[41:10],
                             want[43:42], d[43:42]);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;

    solve_scoreboard sb;
    int  idle_pct  = 0;
    int  stall_pct = 0;
    int  cycles    = 0;
    int  items_sent = 0;
    logic [9:0] solved_rows [$];   // rows whose solution memory entry is written

    sparse_triangular_solve_csr dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The watchdog ends a hung run.
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("[sparse_triangular_solve_csr] ERROR");
                $finish;
            end
        end
    end

    // Result side: ready is changed at the falling edge, transactions are
    // taken and checked at the rising edge.
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = aresetn && ($urandom_range(99) >= stall_pct);
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_row(m_tdata);
        end
    end

    // Sends one transaction, with random idle cycles ahead of it, and holds it
    // until the block accepts it.
    task automatic send_item(logic [9:0] row, logic [9:0] col, logic [31:0] coef,
                             logic [31:0] rhs, logic [31:0] dg, bit has_entry, bit last);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata  = {8'h00, dg, rhs, coef, col, row};
        s_tuser  = has_entry;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(s_tdata, has_entry, last);
        items_sent++;
        if (last) solved_rows.insert(solved_rows.size(), row);
    endtask

    // Mostly moderate Q16.16 values, with the extremes mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom;
            4: return 32'(-$urandom_range(1 << 20));
            default: return $urandom_range(1 << 20);
        endcase
    endfunction

    function automatic logic [9:0] pick_col();
        return solved_rows[$urandom_range(solved_rows.size() - 1)];
    endfunction

    // One well-formed row with random content, sometimes preceded by noise:
    // a stray empty marker or a nonzero carrying another row index.
    task automatic send_random_row();
        int          n;
        logic [9:0]  row;
        logic [31:0] rhs, dg;
        row = 10'($urandom);
        rhs = pick_value();
        dg  = ($urandom_range(19) == 0) ? 32'h0 : pick_value();
        if (dg == 0 && $urandom_range(3) != 0) dg = 32'h0001_0000;
        n = ($urandom_range(15) == 0) ? $urandom_range(12) : $urandom_range(4);
        if ($urandom_range(9) == 0)
            send_item(10'($urandom), 10'($urandom), $urandom, $urandom, $urandom, 0, 0);
        if ($urandom_range(9) == 0)
            send_item(10'($urandom), pick_col(), pick_value(), $urandom, $urandom, 1, 0);
        if (n == 0) begin
            send_item(row, 10'($urandom), $urandom, rhs, dg, 0, 1);
        end else begin
            for (int i = 0; i < n; i++)
                send_item(row, pick_col(), pick_value(), pick_value(), pick_value(),
                          1, i == n - 1);
            if (n > 0) begin end
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed rows: extremes of the fields, zero diagonal, quotient
        // saturation, row change without a closing item, stray empty marker.
        send_item(10'd0, 10'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 0, 1);
        send_item(10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 0, 1);
        send_item(10'd5, 10'd0, 32'h0, 32'h8000_0000, 32'hFFFF_0000, 0, 1);
        send_item(10'd6, 10'd0, 32'h0, 32'h1234_5678, 32'h0, 0, 1);
        send_item(10'd7, 10'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1, 0);
        send_item(10'd7, 10'd1023, 32'h8000_0000, 32'h0, 32'h0, 1, 0);
        send_item(10'd7, 10'd0, 32'h0000_0001, 32'h1234_5678, 32'h0000_0003, 1, 1);
        send_item(10'd100, 10'd7, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0, 1, 0);
        send_item(10'd8, 10'd1023, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1, 1);
        send_item(10'd9, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_item(10'd9, 10'd0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 0, 1);
        send_item(10'd10, 10'd0, 32'h0, 32'h4000_0000, 32'h0000_0001, 0, 1);
        send_item(10'd11, 10'd5, 32'h7FFF_FFFF, 32'h0, 32'h0, 1, 0);
        send_item(10'd11, 10'd6, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
        send_item(10'd12, 10'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
        @(negedge aclk);
        s_tvalid = 0;
        drain();

        // Four backpressure phases of random rows.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 58) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 58) : 0;
            repeat (185) send_random_row();
            @(negedge aclk);
            s_tvalid = 0;
            drain();
        end

        $display("covered %0d input transactions and %0d solved rows in %0d cycles",
                 items_sent, sb.rows_checked, cycles);
        $display("phases: no idling, idle sender, stalled receiver, both at once");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[sparse_triangular_solve_csr] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending.size());
            $display("[sparse_triangular_solve_csr] ERROR");
        end
        $finish;
    end

endmodule
